// File: sv/deht_pkg.sv
// Shared types and constants for the directory entry hash table.
// Field widths, operation and status codes, and the slot entry layout.
// No dependencies.
`default_nettype none

package deht_pkg;

  // Default table size
  localparam int SLOTS_DEFAULT = 64;

  // Field widths
  localparam int OP_W     = 3;
  localparam int HASH_W   = 64;
  localparam int LEN_W    = 8;
  localparam int INODE_W  = 56;
  localparam int OFF_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int EOFF_W   = 33;
  localparam int COUNT_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
  localparam logic [OP_W-1:0] OP_PREDICT = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // One slot of the table as stored in RAM
  typedef struct packed {
    logic               valid;
    logic [INODE_W-1:0] inode;
    logic [HASH_W-1:0]  hash;
    logic [LEN_W-1:0]   name_len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: sv/deht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module deht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/deht_hash_mod.sv
// Reduces a 64-bit name hash modulo the slot count to the probe start slot.
// Power-of-two sizes register the low hash bits; other sizes load the hash, then reduce eight hash bits per cycle.
// Depends on deht_pkg.
`default_nettype none

module deht_hash_mod
  import deht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [HASH_W-1:0]        hash,
  output logic                          done,
  output logic      [$clog2(SLOTS)-1:0] rem
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;

  if (POW2) begin : g_pow2
    logic             done_r;
    logic [IDX_W-1:0] rem_r;

    // Take the low hash bits
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        rem_r <= hash[IDX_W-1:0];
      end
    end

    assign done = done_r;
    assign rem  = rem_r;
  end else begin : g_div
    localparam int CHUNK  = 8;
    localparam int STEPS  = HASH_W / CHUNK;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [IDX_W:0] SLOTS_C = (IDX_W + 1)'(SLOTS);

    logic              busy_r;
    logic              done_r;
    logic [STEP_W-1:0] step_r;
    logic [HASH_W-1:0] sh_r;
    logic [IDX_W-1:0]  rem_r;
    logic [IDX_W-1:0]  rem_nxt;

    // Shift in eight hash bits, reducing after each one
    always_comb begin
      logic [IDX_W:0] acc;
      acc = {1'b0, rem_r};
      for (int k = 0; k < CHUNK; k++) begin
        acc = {acc[IDX_W-1:0], sh_r[HASH_W-1-k]};
        if (acc >= SLOTS_C) begin
          acc = acc - SLOTS_C;
        end
      end
      rem_nxt = acc[IDX_W-1:0];
    end

    // Step control
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
        step_r <= '0;
      end else begin
        done_r <= 1'b0;
        if (start) begin
          busy_r <= 1'b1;
          step_r <= '0;
        end else if (busy_r) begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(STEPS - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end

    // Datapath
    always_ff @(posedge clk) begin
      if (start) begin
        sh_r  <= hash;
        rem_r <= '0;
      end else if (busy_r) begin
        sh_r  <= sh_r << CHUNK;
        rem_r <= rem_nxt;
      end
    end

    assign done = done_r;
    assign rem  = rem_r;
  end

endmodule

`default_nettype wire

// File: sv/directory_entry_hash_table.sv
// Directory entry hash table: an open-addressed, linearly probed table of SLOTS slots
// held in one RAM with a registered read. After reset the block runs a clearing
// pass, one slot per cycle, and accepts no item meanwhile (configuration writes
// are always taken). The probe loop issues one RAM read per cycle and checks the
// previous read's data, so the RAM read port sets the rate. An item that needs no
// probe (unused code, zero-length lookup, empty or full table, search offset past
// the table) goes straight to the result state. A lookup, remove, insert or predict
// first passes the hash through the modulo unit, then probes from the start slot.
// A search from slot b probes slots b up to the last slot without wrapping. Slots
// found by an insert or remove are written back in the cycle they are found. A
// finished result waits in the output register while the next item is accepted.
// Depends on deht_pkg, deht_ram and deht_hash_mod.
`default_nettype none

module directory_entry_hash_table
  import deht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic [HASH_W-1:0]   in_name_hash,
  input  wire logic [LEN_W-1:0]    in_name_len,
  input  wire logic [INODE_W-1:0]  in_inode_number,
  input  wire logic [OFF_W-1:0]    in_dir_offset,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [SLOT_W-1:0]   out_slot,
  output logic      [INODE_W-1:0]  out_entry_inode,
  output logic      [HASH_W-1:0]   out_entry_hash,
  output logic      [LEN_W-1:0]    out_entry_name_len,
  output logic      [EOFF_W-1:0]   out_entry_offset,
  output logic      [COUNT_W-1:0]  out_entry_count,
  // Configuration channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [OFF_W-1:0]    cfg_offset_base
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [OFF_W-1:0] SLOTS_OFF = OFF_W'(SLOTS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Control registers
  logic [IDX_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    iss_left_r, iss_left_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]    chk_pos_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OFF_W-1:0]    offset_base_r;
  logic                out_valid_r;

  // Captured item
  logic [OP_W-1:0]     op_r;
  logic [HASH_W-1:0]   hash_r;
  logic [LEN_W-1:0]    len_r;
  logic [INODE_W-1:0]  ino_r;

  // Result staging
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  entry_t              res_entry_r, res_entry_nxt;

  // Output registers
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [INODE_W-1:0]  out_inode_r;
  logic [HASH_W-1:0]   out_hash_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [EOFF_W-1:0]   out_offset_r;
  logic [COUNT_W-1:0]  out_count_r;

  // RAM and modulo unit
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  entry_t              ram_wentry;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;
  logic                mod_start, mod_done;
  logic [IDX_W-1:0]    mod_rem;

  // Misc
  logic                in_acc, out_load, issue, hit, stop, match_mode;
  logic                tbl_empty, tbl_full, srch_in;
  logic [OFF_W-1:0]    srch_base;
  logic [IDX_W+SLOT_W-1:0]  slot_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [EOFF_W-1:0]   offset_sum;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || out_ready;
  assign rd_entry  = entry_t'(ram_rdata);
  assign tbl_empty = (cnt_r == '0);
  assign tbl_full  = (cnt_r == SLOTS_CNT);
  assign issue     = (state_r == S_PROBE) && (iss_left_r != '0);
  assign ram_re    = issue;
  assign ram_raddr = pos_r;
  assign match_mode = (op_r == OP_LOOKUP) || (op_r == OP_REMOVE);

  // Search start slot relative to slot zero
  assign srch_base = (in_dir_offset >= offset_base_r) ? (in_dir_offset - offset_base_r) : '0;
  assign srch_in   = srch_base < SLOTS_OFF;

  // Match test on the slot read last cycle
  always_comb begin
    case (op_r) inside
      OP_LOOKUP:  hit = rd_entry.valid && (rd_entry.hash == hash_r) &&
                        (rd_entry.name_len == len_r);
      OP_REMOVE:  hit = rd_entry.valid && (rd_entry.hash == hash_r) &&
                        (rd_entry.name_len == len_r) && (rd_entry.inode == ino_r);
      OP_INSERT, OP_PREDICT: hit = !rd_entry.valid;
      OP_SEARCH:  hit = rd_entry.valid;
      default:    hit = 1'b0;
    endcase
  end

  // Stop after the last issued slot, or, for lookup and remove, once all used slots have been passed
  assign stop = (iss_left_r == '0) ||
                (match_mode && rd_entry.valid &&
                 (({1'b0, seen_r} + 1'b1) >= {1'b0, cnt_r}));

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    pos_nxt        = pos_r;
    iss_left_nxt   = iss_left_r;
    seen_nxt       = seen_r;
    chk_vld_nxt    = 1'b0;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_entry_nxt  = res_entry_r;
    mod_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = chk_pos_r;
    ram_wentry     = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          // Default: finish at once with nothing found
          res_status_nxt = ST_NOT_FOUND;
          res_idx_nxt    = '0;
          res_entry_nxt  = '0;
          state_nxt      = S_RESP;
          seen_nxt       = '0;
          case (in_operation) inside
            OP_LOOKUP: begin
              if (in_name_len != '0 && !tbl_empty) begin
                mod_start = 1'b1;
                state_nxt = S_HASH;
              end
            end
            OP_REMOVE: begin
              if (!tbl_empty) begin
                mod_start = 1'b1;
                state_nxt = S_HASH;
              end
            end
            OP_INSERT, OP_PREDICT: begin
              if (tbl_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_HASH;
              end
            end
            OP_SEARCH: begin
              if (!tbl_empty && srch_in) begin
                pos_nxt      = srch_base[IDX_W-1:0];
                iss_left_nxt = SLOTS_CNT - CNT_W'(srch_base[IDX_W-1:0]);
                state_nxt    = S_PROBE;
              end
            end
            default: ;
          endcase
        end
      end

      S_HASH: begin
        if (mod_done) begin
          pos_nxt      = mod_rem;
          iss_left_nxt = SLOTS_CNT;
          state_nxt    = S_PROBE;
        end
      end

      S_PROBE: begin
        // Advance the read pointer
        if (issue) begin
          pos_nxt      = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
          iss_left_nxt = iss_left_r - 1'b1;
        end
        chk_vld_nxt = issue;
        if (chk_vld_r) begin
          if (hit) begin
            chk_vld_nxt    = 1'b0;
            res_status_nxt = ST_DONE;
            res_idx_nxt    = chk_pos_r;
            res_entry_nxt  = rd_entry;
            state_nxt      = S_RESP;
            // Write back the slot
            if (op_r == OP_INSERT) begin
              ram_we     = 1'b1;
              ram_wentry = '{valid: 1'b1, inode: ino_r, hash: hash_r, name_len: len_r};
              cnt_nxt    = cnt_r + 1'b1;
            end else if (op_r == OP_REMOVE) begin
              ram_we     = 1'b1;
              cnt_nxt    = cnt_r - 1'b1;
            end
          end else if (stop) begin
            chk_vld_nxt    = 1'b0;
            res_status_nxt = match_mode || (op_r == OP_SEARCH) ? ST_NOT_FOUND : ST_FULL;
            res_idx_nxt    = '0;
            res_entry_nxt  = '0;
            state_nxt      = S_RESP;
          end else if (match_mode && rd_entry.valid) begin
            seen_nxt = seen_r + 1'b1;
          end
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      chk_vld_r     <= 1'b0;
      cnt_r         <= '0;
      offset_base_r <= '0;
      out_valid_r   <= 1'b0;
      iss_left_r    <= '0;
      seen_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      chk_vld_r  <= chk_vld_nxt;
      cnt_r      <= cnt_nxt;
      iss_left_r <= iss_left_nxt;
      seen_r     <= seen_nxt;
      if (cfg_valid && cfg_ready) begin
        offset_base_r <= cfg_offset_base;
      end
      if (state_r == S_RESP && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    chk_pos_r    <= pos_r;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_entry_r  <= res_entry_nxt;
    if (in_acc) begin
      op_r   <= in_operation;
      hash_r <= in_name_hash;
      len_r  <= in_name_len;
      ino_r  <= in_inode_number;
    end
  end

  // Output register load
  assign slot_ext   = {{SLOT_W{1'b0}}, res_idx_r};
  assign cnt_ext    = {{COUNT_W{1'b0}}, cnt_r};
  assign offset_sum = {1'b0, offset_base_r} + {{(EOFF_W - IDX_W){1'b0}}, res_idx_r};

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= slot_ext[SLOT_W-1:0];
      out_inode_r  <= res_entry_r.inode;
      out_hash_r   <= res_entry_r.hash;
      out_len_r    <= res_entry_r.name_len;
      out_offset_r <= (res_status_r == ST_DONE) ? offset_sum : '0;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_entry_inode    = out_inode_r;
  assign out_entry_hash     = out_hash_r;
  assign out_entry_name_len = out_len_r;
  assign out_entry_offset   = out_offset_r;
  assign out_entry_count    = out_count_r;

  // Slot store
  deht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wentry),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Probe start slot
  deht_hash_mod #(
    .SLOTS(SLOTS)
  ) u_hash_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .hash (in_name_hash),
    .done (mod_done),
    .rem  (mod_rem)
  );

endmodule

`default_nettype wire

// File: sv/deht_checker.sv
// Port-level checker for the directory entry hash table, bound to the top level.
// Depends on deht_pkg and directory_entry_hash_table.
`default_nettype none

module deht_checker
  import deht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [SLOT_W-1:0]   out_slot,
  input wire logic [HASH_W-1:0]   out_entry_hash,
  input wire logic [EOFF_W-1:0]   out_entry_offset,
  input wire logic [COUNT_W-1:0]  out_entry_count
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot) &&
      $stable(out_entry_hash) && $stable(out_entry_count))
    else $error("stalled result changed");

  // One transaction at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // A miss reports no slot and no entry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |->
      out_slot == '0 && out_entry_offset == '0 && out_entry_hash == '0)
    else $error("miss reports slot data");

  // Full is reported only with every slot used
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == COUNT_W'(SLOTS))
    else $error("full reported with free slots");

endmodule

bind directory_entry_hash_table deht_checker #(.SLOTS(SLOTS)) u_deht_checker (.*);

`default_nettype wire
